// ===== hw/rtl/sbd_pkg.sv =====
// Shared types and constants of the six-bit text byte decoder.
`default_nettype none

package sbd_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned VALUE_W  = 6;
   localparam int unsigned STATUS_W = 2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_BYTE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

   // Character boundaries.
   localparam logic [CHAR_W-1:0] CH_LOW_FIRST  = 8'h28;  // '('
   localparam logic [CHAR_W-1:0] CH_LOW_LAST   = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] CH_HIGH_FIRST = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CH_HIGH_LAST  = 8'h7A;  // 'z'
   localparam logic [CHAR_W-1:0] CH_END        = 8'h2E;  // '.'
   localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
   localparam logic [CHAR_W-1:0] HIGH_OFFSET   = 8'd6;

   // Number of data values carried by one tag.
   localparam logic [1:0] PAIRS_PER_TAG = 2'd3;

   typedef enum logic [1:0] {
      KIND_BLANK,
      KIND_DATA,
      KIND_END,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   value;
   } class_type;

   typedef struct packed {
      logic [CHAR_W-1:0]    out_byte;
      logic [STATUS_W-1:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sbd_classify.sv =====
// Character classifier: sorts a text byte and yields its six-bit value.
`default_nettype none

module sbd_classify (
   input  wire logic [sbd_pkg::CHAR_W-1:0] char_in,
   output sbd_pkg::class_type              class_out
);

   logic [sbd_pkg::CHAR_W-1:0] low_diff;
   logic [sbd_pkg::CHAR_W-1:0] high_diff;

   assign low_diff  = char_in - sbd_pkg::CH_LOW_FIRST;
   assign high_diff = char_in - sbd_pkg::CH_HIGH_FIRST + sbd_pkg::HIGH_OFFSET;

   always_comb begin
      class_out.kind  = sbd_pkg::KIND_ERROR;
      class_out.value = '0;
      if (char_in == sbd_pkg::CH_SPACE ||
          (char_in >= sbd_pkg::CH_TAB && char_in <= sbd_pkg::CH_CR)) begin
         class_out.kind = sbd_pkg::KIND_BLANK;
      end else if (char_in >= sbd_pkg::CH_LOW_FIRST && char_in <= sbd_pkg::CH_LOW_LAST) begin
         class_out.kind  = sbd_pkg::KIND_DATA;
         class_out.value = low_diff[sbd_pkg::VALUE_W-1:0];
      end else if (char_in >= sbd_pkg::CH_HIGH_FIRST &&
                   char_in <= sbd_pkg::CH_HIGH_LAST) begin
         class_out.kind  = sbd_pkg::KIND_DATA;
         class_out.value = high_diff[sbd_pkg::VALUE_W-1:0];
      end else if (char_in == sbd_pkg::CH_END) begin
         class_out.kind = sbd_pkg::KIND_END;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sbd_out_stage.sv =====
// Result register with valid and stall towards the consumer.
`default_nettype none

module sbd_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire sbd_pkg::rsp_type  data_in,
   output logic                   can_load,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sbd_pkg::rsp_type       data_out
);

   logic             valid_ff;
   logic             valid_in;
   sbd_pkg::rsp_type data_ff;

   // The register frees up in the same cycle its contents are transferred.
   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/six_bit_text_byte_decoder.sv =====
// Top level of the six-bit text byte decoder.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_in_byte[7:0]
//   rsp_      out        rsp_valid/rsp_stall   rsp_out_byte[7:0], rsp_status[1:0]
//
// A character is taken into an input register, then decoded in one pass of
// short logic that writes the result register, so one character is taken in
// every cycle while the consumer keeps up. Reset (synchronous, active high)
// empties both registers, clears the tag and leaves the decoder active. A
// stall on the result side holds the input register only when its character
// would give a result; blanks, tags and characters after the end move on
// regardless.
`default_nettype none

module six_bit_text_byte_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sbd_pkg::CHAR_W-1:0]    req_in_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [sbd_pkg::CHAR_W-1:0]         rsp_out_byte,
   output logic [sbd_pkg::STATUS_W-1:0]       rsp_status
);

   // Input register.
   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [sbd_pkg::CHAR_W-1:0]    in_char_ff;

   // Decoder state: remaining tag bits, data values still covered by the
   // tag (zero means the next value is a tag), and the halt flag set by the
   // end marker or an invalid character.
   logic [sbd_pkg::VALUE_W-1:0]   tag_ff;
   logic [sbd_pkg::VALUE_W-1:0]   tag_in;
   logic [1:0]                    pairs_ff;
   logic [1:0]                    pairs_in;
   logic                          halted_ff;
   logic                          halted_in;

   sbd_pkg::class_type            char_class;
   sbd_pkg::rsp_type              rsp_next;
   sbd_pkg::rsp_type              rsp_data;
   logic                          gives_result;
   logic                          out_can_load;
   logic                          consume;
   logic                          req_take;

   sbd_classify u_classify (
      .char_in   (in_char_ff),
      .class_out (char_class)
   );

   // Work out what the held character does.
   always_comb begin
      gives_result      = 1'b0;
      tag_in            = tag_ff;
      pairs_in          = pairs_ff;
      halted_in         = halted_ff;
      rsp_next.out_byte = '0;
      rsp_next.status   = sbd_pkg::ST_BYTE;
      if (!halted_ff) begin
         unique case (char_class.kind)
            sbd_pkg::KIND_BLANK: begin
            end
            sbd_pkg::KIND_DATA: begin
               if (pairs_ff == 2'd0) begin
                  tag_in   = char_class.value;
                  pairs_in = sbd_pkg::PAIRS_PER_TAG;
               end else begin
                  // Each data value takes the tag's low pair, bits swapped.
                  gives_result      = 1'b1;
                  rsp_next.out_byte = {char_class.value, tag_ff[0], tag_ff[1]};
                  tag_in            = {2'b00, tag_ff[sbd_pkg::VALUE_W-1:2]};
                  pairs_in          = pairs_ff - 2'd1;
               end
            end
            sbd_pkg::KIND_END: begin
               gives_result    = 1'b1;
               rsp_next.status = sbd_pkg::ST_END;
               halted_in       = 1'b1;
            end
            sbd_pkg::KIND_ERROR: begin
               gives_result    = 1'b1;
               rsp_next.status = sbd_pkg::ST_ERROR;
               halted_in       = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // The held character leaves once its result, if any, has a place to go.
   assign consume     = in_valid_ff && (!gives_result || out_can_load);
   assign req_stall   = in_valid_ff && !consume;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take ? 1'b1 : (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         tag_ff      <= '0;
         pairs_ff    <= '0;
         halted_ff   <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (consume) begin
            tag_ff    <= tag_in;
            pairs_ff  <= pairs_in;
            halted_ff <= halted_in;
         end
      end
      if (req_take) begin
         in_char_ff <= req_in_byte;
      end
   end

   sbd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && gives_result),
      .data_in   (rsp_next),
      .can_load  (out_can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .data_out  (rsp_data)
   );

   assign rsp_out_byte = rsp_data.out_byte;
   assign rsp_status   = rsp_data.status;

endmodule

`default_nettype wire

// ===== hw/rtl/sbd_checker.sv =====
// Port-level checks of the six-bit text byte decoder, bound to the top level.
`default_nettype none

module sbd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [sbd_pkg::CHAR_W-1:0]    req_in_byte,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [sbd_pkg::CHAR_W-1:0]    rsp_out_byte,
   input wire logic [sbd_pkg::STATUS_W-1:0]  rsp_status
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status))
      else $error("stalled result changed");

   // End and error reports carry a zero byte.
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sbd_pkg::ST_BYTE |-> rsp_out_byte == '0)
      else $error("end or error result with non-zero byte");

   // Nothing follows a transferred end or error report.
   a_quiet_after_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_status != sbd_pkg::ST_BYTE |=> !rsp_valid)
      else $error("result after end or error");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // The input side only stalls while a result is waiting under a stall.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no blocked result");

endmodule

bind six_bit_text_byte_decoder sbd_checker u_sbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_in_byte  (req_in_byte),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_status   (rsp_status)
);

`default_nettype wire

// ===== dv/tb_six_bit_text_byte_decoder.sv =====
// Self-checking testbench for the six-bit text byte decoder: directed table, then random text.
module tb_six_bit_text_byte_decoder;

   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int QUIET_LIMIT   = 2000;
   // Cycles to watch after the last awaited result, for stray results.
   localparam int TAIL_CYCLES   = 12;
   localparam int ITEMS_PER_SET = 600;
   localparam int NOISE_ITEMS   = 40;

   typedef logic [sbd_pkg::CHAR_W-1:0]  char_type;
   typedef logic [sbd_pkg::VALUE_W-1:0] value_type;

   // How a stimulus row is checked: no result typed in, a typed result, or the predictor.
   typedef enum logic [1:0] {
      ROW_SILENT,
      ROW_TYPED,
      ROW_PREDICTED
   } row_kind_type;

   typedef struct {
      char_type                      ch;
      row_kind_type                  how;
      char_type                      out_byte;
      logic [sbd_pkg::STATUS_W-1:0]  status;
   } text_row_type;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   char_type                      req_in_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   char_type                      rsp_out_byte;
   logic [sbd_pkg::STATUS_W-1:0]  rsp_status;

   six_bit_text_byte_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status)
   );

   // Directed text. After reset the first non-blank character is a tag. A tag of
   // zero leaves the low two bits of each byte clear, so the bytes are the data
   // value times four; a tag of 63 sets them, so '(' and 'z' give 0x03 and 0xFF.
   // The remaining rows walk the other ends of both character ranges and every
   // blank code, and are left to the predictor.
   text_row_type text_rows [21] = '{
      '{8'h20, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // space before the first tag
      '{8'h28, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // '(' as tag, value 0
      '{8'h28, ROW_TYPED,     8'h00, sbd_pkg::ST_BYTE},   // '(' value 0
      '{8'h09, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // tab
      '{8'h7A, ROW_TYPED,     8'hFC, sbd_pkg::ST_BYTE},   // 'z' value 63
      '{8'h0D, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // carriage return
      '{8'h2D, ROW_TYPED,     8'h14, sbd_pkg::ST_BYTE},   // '-' value 5
      '{8'h7A, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // 'z' as tag, all ones
      '{8'h28, ROW_TYPED,     8'h03, sbd_pkg::ST_BYTE},
      '{8'h0A, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // line feed
      '{8'h7A, ROW_TYPED,     8'hFF, sbd_pkg::ST_BYTE},
      '{8'h0B, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // vertical tab
      '{8'h41, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE},   // 'A' value 6
      '{8'h0C, ROW_SILENT,    8'h00, sbd_pkg::ST_BYTE},   // form feed
      '{8'h41, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE},   // 'A' as tag
      '{8'h29, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE},   // ')'
      '{8'h5A, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE},   // 'Z'
      '{8'h61, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE},   // 'a'
      '{8'h2C, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE},   // ',' as tag
      '{8'h2B, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE},   // '+'
      '{8'h59, ROW_PREDICTED, 8'h00, sbd_pkg::ST_BYTE}    // 'Y'
   };

   // Characters just outside the accepted ranges, and the two extreme byte values, used for the closing error.
   char_type near_miss_chars [8] = '{
      8'h08, 8'h0E, 8'h27, 8'h2F, 8'h40, 8'h7B, 8'h00, 8'hFF
   };

   // The predictor's own copy of the decoder state.
   value_type  tag_word        = '0;
   logic [2:0] tag_bits_left   = '0;
   bit         decoder_stopped = 1'b0;

   sbd_pkg::rsp_type decoded_q [$];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int chars_sent     = 0;
   int chars_ignored  = 0;
   int bytes_decoded  = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;
   logic [sbd_pkg::STATUS_W-1:0] closing_status = sbd_pkg::ST_BYTE;

   // A free-running clock with a period of two time units.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out what one character does to the decoder and whether it yields a result.
   function automatic bit decode_char(input char_type ch, output sbd_pkg::rsp_type res);
      value_type val;
      bit        is_data;
      res     = '0;
      val     = '0;
      is_data = 1'b1;
      // Once stopped, everything is ignored; blanks never change anything.
      if (decoder_stopped || ch == sbd_pkg::CH_SPACE ||
          (ch >= sbd_pkg::CH_TAB && ch <= sbd_pkg::CH_CR))
         return 1'b0;
      if (ch >= sbd_pkg::CH_LOW_FIRST && ch <= sbd_pkg::CH_LOW_LAST)
         val = value_type'(ch - sbd_pkg::CH_LOW_FIRST);
      else if (ch >= sbd_pkg::CH_HIGH_FIRST && ch <= sbd_pkg::CH_HIGH_LAST)
         val = value_type'(ch - sbd_pkg::CH_HIGH_FIRST + sbd_pkg::HIGH_OFFSET);
      else
         is_data = 1'b0;
      if (!is_data) begin
         decoder_stopped = 1'b1;
         res.status = (ch == sbd_pkg::CH_END) ? sbd_pkg::ST_END : sbd_pkg::ST_ERROR;
         return 1'b1;
      end
      // With no tag bits left the value is the next tag and yields nothing.
      if (tag_bits_left == 3'd0) begin
         tag_word      = val;
         tag_bits_left = 3'd6;
         return 1'b0;
      end
      // The tag's two lowest bits go into the byte in swapped order.
      res.out_byte  = {val, tag_word[0], tag_word[1]};
      res.status    = sbd_pkg::ST_BYTE;
      tag_word      = tag_word >> 2;
      tag_bits_left = tag_bits_left - 3'd2;
      return 1'b1;
   endfunction

   // Offers one character, waits for its transfer and records what it should give.
   // Entered and left at a falling edge, where all inputs change.
   task automatic send_char(input char_type ch, input row_kind_type how,
                            input sbd_pkg::rsp_type typed);
      sbd_pkg::rsp_type res;
      bit               gives;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= ch;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // The transfer has happened at this edge; the predictor always advances so
      // that its state stays in step, even where the row types in its own result.
      gives = decode_char(ch, res);
      if (!gives)
         chars_ignored++;
      case (how)
         ROW_TYPED: begin
            decoded_q.push_back(typed);
         end
         ROW_PREDICTED: begin
            if (gives)
               decoded_q.push_back(res);
         end
         default: begin
         end
      endcase
      chars_sent++;
      @(negedge clock);
   endtask

   // The receiver stalls at random; the rate changes with each set of items.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Every result transfer is matched against the oldest awaited result.
   always @(posedge clock) begin
      sbd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: result with nothing awaited: expected none, actual byte %h status %0d",
                     $time, rsp_out_byte, rsp_status);
            mismatches++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h",
                        $time, want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatches++;
            end
            if (want.status == sbd_pkg::ST_BYTE)
               bytes_decoded++;
         end
      end
   end

   // A run in which nothing moves on either channel for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("six_bit_text_byte_decoder: mismatch");
            $finish;
         end
      end
   end

   initial begin
      sbd_pkg::rsp_type res;
      char_type         ch;
      int               val;
      res = '0;
      ch  = '0;
      val = 0;
      // Reset is held from the start and released at a falling edge.
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Three sets of items: a busy receiver with a quick sender, then the reverse,
      // then both sides flat out. The directed table runs in the first set.
      for (int set = 0; set < 3; set++) begin
         case (set)
            0: begin
               send_gap_pct   = 15;
               recv_stall_pct = 61;
            end
            1: begin
               send_gap_pct   = 61;
               recv_stall_pct = 15;
            end
            default: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
         endcase
         if (set == 0) begin
            foreach (text_rows[i]) begin
               res.out_byte = text_rows[i].out_byte;
               res.status   = text_rows[i].status;
               send_char(text_rows[i].ch, text_rows[i].how, res);
            end
         end
         // Well-formed text with random values: any stop here would silence the
         // rest of the run, since the decoder only restarts from reset.
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            if ($urandom_range(0, 99) < 12) begin
               ch = ($urandom_range(0, 5) == 0) ?
                    sbd_pkg::CH_SPACE :
                    char_type'(sbd_pkg::CH_TAB + $urandom_range(0, 4));
            end else begin
               val = $urandom_range(0, 63);
               ch  = (val < sbd_pkg::HIGH_OFFSET) ?
                     char_type'(sbd_pkg::CH_LOW_FIRST + val) :
                     char_type'(sbd_pkg::CH_HIGH_FIRST + (val - sbd_pkg::HIGH_OFFSET));
            end
            send_char(ch, ROW_PREDICTED, res);
         end
      end

      // The text closes with either the end marker or an invalid character; an
      // invalid one is half the time a near neighbour of a valid range.
      if ($urandom_range(0, 1) == 0) begin
         ch = sbd_pkg::CH_END;
      end else if ($urandom_range(0, 1) == 0) begin
         ch = near_miss_chars[3'($urandom_range(0, 7))];
      end else begin
         do
            ch = char_type'($urandom_range(0, 255));
         while (ch == sbd_pkg::CH_SPACE ||
                (ch >= sbd_pkg::CH_TAB && ch <= sbd_pkg::CH_CR) ||
                ch == sbd_pkg::CH_END ||
                (ch >= sbd_pkg::CH_LOW_FIRST && ch <= sbd_pkg::CH_LOW_LAST) ||
                (ch >= sbd_pkg::CH_HIGH_FIRST && ch <= sbd_pkg::CH_HIGH_LAST));
      end
      closing_status = (ch == sbd_pkg::CH_END) ? sbd_pkg::ST_END : sbd_pkg::ST_ERROR;
      send_char(ch, ROW_PREDICTED, res);

      // Once stopped the decoder must stay silent whatever arrives, blanks and a
      // second end marker included; these random bytes also drive the top bit.
      for (int n = 0; n < NOISE_ITEMS; n++) begin
         case (n)
            0:       ch = sbd_pkg::CH_SPACE;
            1:       ch = sbd_pkg::CH_END;
            2:       ch = 8'hFF;
            default: ch = char_type'($urandom_range(0, 255));
         endcase
         send_char(ch, ROW_PREDICTED, res);
      end
      req_valid <= 1'b0;

      // Drain the awaited results, then keep watching for stray ones.
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d characters (%0d gave no result); %0d bytes decoded.",
               chars_sent, chars_ignored, bytes_decoded);
      $display("Text closed by %s, followed by %0d characters after the stop.",
               (closing_status == sbd_pkg::ST_END) ? "the end marker" : "an invalid character",
               NOISE_ITEMS);
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("six_bit_text_byte_decoder: match");
      end else begin
         $display("six_bit_text_byte_decoder: mismatch");
      end
      $finish;
   end

endmodule
